FILE: rtl/skrt_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// skrt_pkg
// Shared transaction types and codes of the sorted key record table.
// ----------------------------------------------------------------------------
package skrt_pkg;

  localparam logic [2:0] FN_ADD    = 3'd0;
  localparam logic [2:0] FN_GET    = 3'd1;
  localparam logic [2:0] FN_UPDATE = 3'd2;
  localparam logic [2:0] FN_DELETE = 3'd3;
  localparam logic [2:0] FN_QUERY  = 3'd4;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_DUP      = 2'd2;
  localparam logic [1:0] ST_NOTFOUND = 2'd3;

  typedef struct packed {
    logic [2:0]  func;
    logic [31:0] key_id;
    logic [63:0] record_data;
    logic        record_deleted;
    logic [31:0] record_stamp;
    logic [31:0] now_time;
  } in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [63:0] found_data;
    logic        found_deleted;
    logic [31:0] found_stamp;
    logic [8:0]  live_count;
    logic [31:0] next_free_key;
  } out_t;

endpackage
`default_nettype wire

FILE: rtl/skrt_store.sv
`default_nettype none
// ----------------------------------------------------------------------------
// skrt_store
// Record memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module skrt_store #(
  parameter int DEPTH = 256,
  parameter int AW    = 8,
  parameter int W     = 129
) (
  input  wire logic          clk,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  output logic      [W-1:0]  rd_data,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [W-1:0]  wr_data
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

FILE: rtl/skrt_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// skrt_ctrl
// Sequencer: binary search over the record memory, insert shift,
// read-modify-write of found entries and the table counters.
// ----------------------------------------------------------------------------
module skrt_ctrl
  import skrt_pkg::*;
#(
  parameter int CAPACITY    = 256,
  parameter int RECORD_BITS = 64,
  parameter int AW          = 8,
  parameter int CW          = 9,
  parameter int W           = 129
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire in_t           in_data,
  output logic               res_valid,
  input  wire logic          res_ready,
  output out_t               res_data,
  output logic               mem_rd_en,
  output logic      [AW-1:0] mem_rd_addr,
  input  wire logic [W-1:0]  mem_rd_data,
  output logic               mem_wr_en,
  output logic      [AW-1:0] mem_wr_addr,
  output logic      [W-1:0]  mem_wr_data
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SRD  = 3'd1;
  localparam logic [2:0] S_SCMP = 3'd2;
  localparam logic [2:0] S_EXEC = 3'd3;
  localparam logic [2:0] S_SHFT = 3'd4;
  localparam logic [2:0] S_INS  = 3'd5;
  localparam logic [2:0] S_RESP = 3'd6;

  // record layout: key | data | deleted | stamp
  localparam int DEL_B = 32;
  localparam int DAT_L = 33;
  localparam int KEY_L = RECORD_BITS + 33;

  logic [2:0]    state_r, state_nxt;
  in_t           req_r, req_nxt;
  logic [CW-1:0] lo_r, lo_nxt, hi_r, hi_nxt, mid_r, mid_nxt;
  logic          hit_r, hit_nxt;
  logic [W-1:0]  rec_r, rec_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt, live_r, live_nxt;
  logic [31:0]   nkey_r, nkey_nxt;
  logic [1:0]    status_r, status_nxt;
  logic          fnd_r, fnd_nxt;
  logic [CW-1:0] sh_idx_r, sh_idx_nxt, sh_left_r, sh_left_nxt, sh_src_r, sh_src_nxt;
  logic          sh_pend_r, sh_pend_nxt;

  logic [CW-1:0] mid_c, sh_dst;
  logic [31:0]   rd_key;
  logic [W-1:0]  new_rec;
  logic [RECORD_BITS+63:0] data_ext;
  logic [CW+8:0] live_ext;

  assign mid_c    = lo_r + ((hi_r - lo_r) >> 1);
  assign sh_dst   = sh_src_r + CW'(1);
  assign rd_key   = mem_rd_data[KEY_L +: 32];
  assign new_rec  = {req_r.key_id, req_r.record_data[RECORD_BITS-1:0],
                     req_r.record_deleted, req_r.record_stamp};
  assign data_ext = {64'd0, rec_r[DAT_L +: RECORD_BITS]};
  assign live_ext = {9'd0, live_r};

  assign in_ready  = (state_r == S_IDLE);
  assign res_valid = (state_r == S_RESP);

  always_comb begin
    res_data.status        = status_r;
    res_data.found_data    = fnd_r ? data_ext[63:0] : 64'd0;
    res_data.found_deleted = fnd_r ? rec_r[DEL_B] : 1'b0;
    res_data.found_stamp   = fnd_r ? rec_r[31:0] : 32'd0;
    res_data.live_count    = live_ext[8:0];
    res_data.next_free_key = nkey_r;
  end

  always_comb begin
    state_nxt   = state_r;
    req_nxt     = req_r;
    lo_nxt      = lo_r;
    hi_nxt      = hi_r;
    mid_nxt     = mid_r;
    hit_nxt     = hit_r;
    rec_nxt     = rec_r;
    cnt_nxt     = cnt_r;
    live_nxt    = live_r;
    nkey_nxt    = nkey_r;
    status_nxt  = status_r;
    fnd_nxt     = fnd_r;
    sh_idx_nxt  = sh_idx_r;
    sh_left_nxt = sh_left_r;
    sh_src_nxt  = sh_src_r;
    sh_pend_nxt = 1'b0;
    mem_rd_en   = 1'b0;
    mem_rd_addr = mid_c[AW-1:0];
    mem_wr_en   = 1'b0;
    mem_wr_addr = lo_r[AW-1:0];
    mem_wr_data = new_rec;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          req_nxt    = in_data;
          lo_nxt     = '0;
          hi_nxt     = cnt_r;
          hit_nxt    = 1'b0;
          status_nxt = ST_OK;
          fnd_nxt    = 1'b0;
          priority if (in_data.func == FN_ADD && cnt_r == CW'(CAPACITY)) begin
            status_nxt = ST_FULL;
            state_nxt  = S_RESP;
          end else if (in_data.func == FN_ADD || in_data.func == FN_GET ||
                       in_data.func == FN_UPDATE || in_data.func == FN_DELETE) begin
            state_nxt = S_SRD;
          end else begin
            state_nxt = S_RESP;
          end
        end
      end
      S_SRD: begin
        if (lo_r < hi_r) begin
          mem_rd_en = 1'b1;
          mid_nxt   = mid_c;
          state_nxt = S_SCMP;
        end else begin
          state_nxt = S_EXEC;
        end
      end
      S_SCMP: begin
        // the last probe that narrows hi sits at the final position
        if (rd_key < req_r.key_id) begin
          lo_nxt = mid_r + CW'(1);
        end else begin
          hi_nxt  = mid_r;
          hit_nxt = (rd_key == req_r.key_id);
          rec_nxt = mem_rd_data;
        end
        state_nxt = S_SRD;
      end
      S_EXEC: begin
        state_nxt = S_RESP;
        unique case (req_r.func)
          FN_ADD: begin
            if (hit_r) begin
              status_nxt = ST_DUP;
            end else begin
              sh_idx_nxt  = cnt_r - CW'(1);
              sh_left_nxt = cnt_r - lo_r;
              state_nxt   = S_SHFT;
            end
          end
          FN_GET: begin
            if (hit_r) fnd_nxt = 1'b1;
            else status_nxt = ST_NOTFOUND;
          end
          FN_UPDATE: begin
            if (hit_r) begin
              mem_wr_en   = 1'b1;
              mem_wr_data = {rec_r[KEY_L +: 32], req_r.record_data[RECORD_BITS-1:0],
                             req_r.record_deleted, req_r.record_stamp};
              if (rec_r[DEL_B] && !req_r.record_deleted) live_nxt = live_r + CW'(1);
              else if (!rec_r[DEL_B] && req_r.record_deleted) live_nxt = live_r - CW'(1);
            end else begin
              status_nxt = ST_NOTFOUND;
            end
          end
          FN_DELETE: begin
            if (hit_r) begin
              mem_wr_en   = 1'b1;
              mem_wr_data = {rec_r[W-1:DEL_B+1], 1'b1, req_r.now_time};
              if (!rec_r[DEL_B]) live_nxt = live_r - CW'(1);
            end else begin
              status_nxt = ST_NOTFOUND;
            end
          end
          default: begin
          end
        endcase
      end
      S_SHFT: begin
        // read entry i while entry i+2 takes entry i+1, read the cycle before
        if (sh_pend_r) begin
          mem_wr_en   = 1'b1;
          mem_wr_addr = sh_dst[AW-1:0];
          mem_wr_data = mem_rd_data;
        end
        if (sh_left_r != '0) begin
          mem_rd_en   = 1'b1;
          mem_rd_addr = sh_idx_r[AW-1:0];
          sh_pend_nxt = 1'b1;
          sh_src_nxt  = sh_idx_r;
          sh_idx_nxt  = sh_idx_r - CW'(1);
          sh_left_nxt = sh_left_r - CW'(1);
        end else if (!sh_pend_r) begin
          state_nxt = S_INS;
        end
      end
      S_INS: begin
        mem_wr_en = 1'b1;
        cnt_nxt   = cnt_r + CW'(1);
        if (!req_r.record_deleted) live_nxt = live_r + CW'(1);
        if (req_r.key_id >= nkey_r) nkey_nxt = req_r.key_id + 32'd1;
        state_nxt = S_RESP;
      end
      S_RESP: begin
        if (res_ready) state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      cnt_r     <= '0;
      live_r    <= '0;
      nkey_r    <= 32'd1;
      sh_pend_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      cnt_r     <= cnt_nxt;
      live_r    <= live_nxt;
      nkey_r    <= nkey_nxt;
      sh_pend_r <= sh_pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r     <= req_nxt;
    lo_r      <= lo_nxt;
    hi_r      <= hi_nxt;
    mid_r     <= mid_nxt;
    hit_r     <= hit_nxt;
    rec_r     <= rec_nxt;
    status_r  <= status_nxt;
    fnd_r     <= fnd_nxt;
    sh_idx_r  <= sh_idx_nxt;
    sh_left_r <= sh_left_nxt;
    sh_src_r  <= sh_src_nxt;
  end

`ifndef SYNTH
  a_cnt_cap: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_live_le_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    live_r <= cnt_r)
    else $error("live count above entry count");

  a_wr_in_use: assert property (@(posedge clk) disable iff (!rst_n)
    mem_wr_en |-> ({{CW{1'b0}}, mem_wr_addr} <= {{AW{1'b0}}, cnt_r}))
    else $error("write beyond the used part of the table");

  a_ins_grows: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_INS |=> cnt_r == $past(cnt_r) + CW'(1))
    else $error("insert did not grow the table");
`endif

endmodule
`default_nettype wire

FILE: rtl/sorted_key_record_table.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_key_record_table
// Table of records kept in ascending key order, with add, get, update,
// soft delete and count query.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one request transaction (func, key and record fields), valid/ready.
//   out_* : one result transaction per request, valid/ready.
//   Requests are handled one at a time. Query and full-table add go straight
//   to the result; get, update, delete and all other adds first run a binary
//   search of at most ceil(log2(entries+1)) probes, each probe reading the
//   record memory through its read port. A successful add then moves the
//   entries from the insert position upward up by one, the shift streaming
//   through the memory at one entry a cycle, and writes the new entry.
//   A new request is taken while the previous result waits in the output
//   register; if the receiver stalls longer, the finished result is held in
//   the sequencer and in_ready stays low.
//   Reset empties the table (entry and live counts zero, next free key one);
//   the memory needs no clearing, only entries below the entry count are read.
// ----------------------------------------------------------------------------
module sorted_key_record_table
  import skrt_pkg::*;
#(
  parameter int CAPACITY    = 256,
  parameter int RECORD_BITS = 64
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire in_t  in_data,
  output logic      out_valid,
  input  wire logic out_ready,
  output out_t      out_data
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int W  = RECORD_BITS + 65;

  logic          res_valid, res_ready;
  out_t          res_data;
  logic          rd_en, wr_en;
  logic [AW-1:0] rd_addr, wr_addr;
  logic [W-1:0]  rd_data, wr_data;
  logic          out_valid_r;
  out_t          out_data_r;

  skrt_ctrl #(
    .CAPACITY(CAPACITY), .RECORD_BITS(RECORD_BITS), .AW(AW), .CW(CW), .W(W)
  ) u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .res_valid(res_valid), .res_ready(res_ready), .res_data(res_data),
    .mem_rd_en(rd_en), .mem_rd_addr(rd_addr), .mem_rd_data(rd_data),
    .mem_wr_en(wr_en), .mem_wr_addr(wr_addr), .mem_wr_data(wr_data)
  );

  skrt_store #(.DEPTH(CAPACITY), .AW(AW), .W(W)) u_store (
    .clk(clk),
    .rd_en(rd_en), .rd_addr(rd_addr), .rd_data(rd_data),
    .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data)
  );

  // output register parts the sequencer from the receiver
  assign res_ready = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_data_r <= res_data;
    end
  end

`ifndef SYNTH
  a_res_lands: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && res_ready |=> out_valid_r && out_data_r == $past(res_data))
    else $error("result transaction not captured in output register");
`endif

endmodule
`default_nettype wire
